// File: sv/plie_pkg.sv
// shared types and constants for the positional list block
package plie_pkg;

   // default list depth
   localparam int PL_CAPACITY = 32;

   // field widths
   localparam int OP_W   = 1;
   localparam int POS_W  = 6;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 6;
   localparam int STS_W  = 2;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [STS_W-1:0] {
      STS_DONE  = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   // output register occupancy
   typedef enum logic {
      OUT_EMPTY = 1'b0,
      OUT_FULL  = 1'b1
   } out_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic exec;      // perform the operation on the accepted word
   } dp_cmd_type;

endpackage

// File: sv/plie_ctrl.sv
// handshake controller: tracks the result register and issues execute
module plie_ctrl
   import plie_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   out_state_type state_ff;
   out_state_type state_in;
   logic          accept;

   // a new word may enter whenever the result register is free or draining
   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         OUT_EMPTY: begin
            if (accept) state_in = OUT_FULL;
         end
         OUT_FULL: begin
            if (accept) state_in = OUT_FULL;
            else if (!rsp_stall) state_in = OUT_EMPTY;
         end
         default: state_in = OUT_EMPTY;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         OUT_EMPTY: begin
            cmd.exec = req_valid;
         end
         OUT_FULL: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            cmd.exec  = req_valid && !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= OUT_EMPTY;
      else state_ff <= state_in;
   end

endmodule

// File: sv/plie_dpath.sv
// datapath: row of list cells, entry count and result register
module plie_dpath
   import plie_pkg::*;
#(
   parameter int CAPACITY = PL_CAPACITY
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic [STS_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0] rsp_taken_value,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty
);

   logic [DATA_W-1:0] cells_ff [CAPACITY];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [STS_W-1:0]  status_ff;
   logic [DATA_W-1:0] taken_ff;
   logic [CNT_W-1:0]  cnt_out_ff;
   logic              empty_ff;

   status_type        status_in;
   logic [DATA_W-1:0] taken_in;
   logic              is_ins;
   logic              pos_zero;
   logic              ins_ok;
   logic              ext_ok;
   logic              full;
   logic [CNT_W:0]    count_p1;

   assign is_ins   = (op_type'(req_opcode) == OP_INSERT);
   assign pos_zero = (req_position == '0);
   assign count_p1 = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign full     = (count_ff == CNT_W'(CAPACITY));

   // operation decode and status
   always_comb begin
      ins_ok    = 1'b0;
      ext_ok    = 1'b0;
      status_in = STS_DONE;
      if (is_ins) begin
         if (pos_zero || ({1'b0, req_position} > count_p1)) status_in = STS_RANGE;
         else if (full) status_in = STS_FULL;
         else ins_ok = 1'b1;
      end else begin
         if (pos_zero || (req_position > count_ff)) status_in = STS_RANGE;
         else ext_ok = 1'b1;
      end
   end

   // entry at the requested position
   always_comb begin
      taken_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ext_ok && (req_position == POS_W'(i + 1))) taken_in = cells_ff[i];
      end
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (ins_ok) count_in = count_ff + CNT_W'(1);
      else if (ext_ok) count_in = count_ff - CNT_W'(1);
   end

   // each cell loads, shifts back, shifts forward or holds
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] below;
      logic [DATA_W-1:0] above;
      logic [DATA_W-1:0] cell_in;
      logic              at_pos;
      logic              after_pos;

      if (gi == 0) begin : g_first
         assign below = '0;
      end else begin : g_mid_lo
         assign below = cells_ff[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign above = '0;
      end else begin : g_mid_hi
         assign above = cells_ff[gi+1];
      end

      assign at_pos    = (req_position == POS_W'(gi + 1));
      assign after_pos = (POS_W'(gi) >= req_position);

      always_comb begin
         cell_in = cells_ff[gi];
         if (ins_ok && at_pos) cell_in = req_value;
         else if (ins_ok && after_pos) cell_in = below;
         else if (ext_ok && (at_pos || after_pos)) cell_in = above;
      end

      always_ff @(posedge clock) begin
         if (cmd.exec) cells_ff[gi] <= cell_in;
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.exec) count_ff <= count_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff  <= status_in;
         taken_ff   <= taken_in;
         cnt_out_ff <= count_in;
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_taken_value = taken_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_is_empty    = empty_ff;

endmodule

// File: sv/positional_list_insert_extract_top.sv
// positional list: one insert or extract per cycle unless the result side stalls
// the result word is valid in the cycle after the request word is accepted
// all cells shift, load or hold in parallel
// the next request is taken in the same cycle the pending result is taken
// reset: synchronous active high, clears the entry count and the result valid
// list cells are not cleared; only entries below the count are ever read
module positional_list_insert_extract_top
   import plie_pkg::*;
#(
   parameter int CAPACITY = PL_CAPACITY
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STS_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0] rsp_taken_value,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty
);

   dp_cmd_type cmd;

   // handshake control
   plie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // list storage and result
   plie_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

// File: sv/plie_checker.sv
// port-level checks for the positional list block and their binding
module plie_checker
   import plie_pkg::*;
#(
   parameter int CAPACITY = PL_CAPACITY
)
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [STS_W-1:0]         rsp_status,
   input logic signed [DATA_W-1:0] rsp_taken_value,
   input logic [CNT_W-1:0]         rsp_entry_count,
   input logic                     rsp_is_empty
);

   // a held result word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_taken_value) && $stable(rsp_entry_count))
      else $error("result word changed while stalled");

   // every accepted request yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no result");

   // empty flag agrees with the count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   // rejected operations return zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_DONE) |-> (rsp_taken_value == '0))
      else $error("rejected operation returned a value");

   // count never passes the capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count above capacity");

endmodule

bind positional_list_insert_extract_top plie_checker #(.CAPACITY(CAPACITY)) u_plie_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_taken_value (rsp_taken_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

// File: dv/positional_list_insert_extract_top_tb.sv
// testbench for the positional list block: directed table, random bursts, shadow list check
`timescale 1ns / 100ps

module positional_list_insert_extract_top_tb;
   import plie_pkg::*;

   localparam int LIST_DEPTH = PL_CAPACITY;
   localparam int HOLD_CYCLES = 60;
   localparam int N_DIR = 19;
   localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

   // one result word as the list reports it
   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  taken;
      logic [CNT_W-1:0]   count;
      logic               empty;
   } list_result_type;

   // one row of the directed table; fixed rows carry a hand-written result
   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  val;
      logic               fixed;
      list_result_type    want;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_opcode;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STS_W-1:0]         rsp_status;
   logic signed [DATA_W-1:0] rsp_taken_value;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic                     rsp_is_empty;

   // shadow copy of the list and the results still owed by the block
   logic [DATA_W-1:0] shadow_list[$];
   list_result_type   pending_results[$];
   dir_row_type       dir_rows [N_DIR];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_request = 1'b0;
   int          hold_left = 0;
   int          error_count = 0;
   int          words_sent = 0;
   int          results_seen = 0;
   int          n_insert_done = 0;
   int          n_extract_done = 0;
   int          n_range_reject = 0;
   int          n_full_reject = 0;
   int          peak_count = 0;

   positional_list_insert_extract_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   // clock
   always #5 clock = ~clock;

   // apply one operation to the shadow list and return the result it should give
   function automatic list_result_type apply_list_op(op_type op, logic [POS_W-1:0] pos,
                                                     logic [DATA_W-1:0] val);
      list_result_type res;
      int p;
      p = pos;
      res.status = STS_DONE;
      res.taken = '0;
      if (op == OP_INSERT) begin
         // range check wins over the full check
         if (p == 0 || p > shadow_list.size() + 1) begin
            res.status = STS_RANGE;
         end else if (shadow_list.size() >= LIST_DEPTH) begin
            res.status = STS_FULL;
         end else begin
            shadow_list.insert(p - 1, val);
            n_insert_done++;
         end
      end else begin
         if (p == 0 || p > shadow_list.size()) begin
            res.status = STS_RANGE;
         end else begin
            res.taken = shadow_list[p - 1];
            shadow_list.delete(p - 1);
            n_extract_done++;
         end
      end
      if (res.status == STS_RANGE) n_range_reject++;
      if (res.status == STS_FULL) n_full_reject++;
      res.count = CNT_W'(shadow_list.size());
      res.empty = (shadow_list.size() == 0);
      if (shadow_list.size() > peak_count) peak_count = shadow_list.size();
      return res;
   endfunction

   // value mix leaning on the extremes
   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(7))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return VAL_NEG1;
         default: return $urandom;
      endcase
   endfunction

   // a position in range for this operation right now; an extract from an empty list gets position 1
   function automatic logic [POS_W-1:0] legal_pos(op_type op);
      if (op == OP_INSERT) return POS_W'($urandom_range(shadow_list.size() + 1, 1));
      if (shadow_list.size() == 0) return POS_W'(1);
      return POS_W'($urandom_range(shadow_list.size(), 1));
   endfunction

   // offer one word, wait for it to be taken, then log what it should return
   task automatic send_word(op_type op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val,
                            logic fixed, list_result_type want);
      list_result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = apply_list_op(op, pos, val);
      pending_results.push_back(fixed ? want : pred);
      words_sent++;
   endtask

   task automatic send_checked(op_type op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
      send_word(op, pos, val, 1'b0, '0);
   endtask

   // random bursts: fill to the top, drain to the bottom, or mixed noise
   task automatic run_phase(int n_words);
      int stop_at;
      int n;
      op_type op;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         case ($urandom_range(2))
            0: begin
               while (shadow_list.size() < LIST_DEPTH)
                  send_checked(OP_INSERT, legal_pos(OP_INSERT), rand_value());
               // pushes against a full list: in range, at the end and at a random position
               send_checked(OP_INSERT, POS_W'($urandom_range(LIST_DEPTH + 1, 1)),
                            rand_value());
               send_checked(OP_INSERT, POS_W'(LIST_DEPTH + 1), rand_value());
               send_checked(OP_INSERT, POS_W'($urandom_range(63)), rand_value());
            end
            1: begin
               while (shadow_list.size() > 0)
                  send_checked(OP_EXTRACT, legal_pos(OP_EXTRACT), rand_value());
               send_checked(OP_EXTRACT, POS_W'($urandom_range(63)), rand_value());
            end
            default: begin
               n = $urandom_range(30, 8);
               repeat (n) begin
                  op = op_type'($urandom_range(1));
                  if ($urandom_range(1))
                     send_checked(op, POS_W'($urandom_range(63)), rand_value());
                  else
                     send_checked(op, legal_pos(op), rand_value());
               end
            end
         endcase
      end
   endtask

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare each taken result word with the oldest expectation
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: status %0d count %0d",
                   rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_taken_value !== want.taken) begin
               $error("taken_value: expected %0d, got %0d",
                      $signed(want.taken), rsp_taken_value);
               error_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               error_count++;
            end
            if (rsp_is_empty !== want.empty) begin
               $error("is_empty: expected %0d, got %0d", want.empty, rsp_is_empty);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin : stimulus
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_opcode   <= OP_INSERT;
      req_position <= '0;
      req_value    <= '0;
      rsp_stall    <= 1'b0;

      dir_rows = '{
         '{OP_EXTRACT, 6'd1,  32'd0,        1'b1, '{STS_RANGE, 32'd0, 6'd0, 1'b1}},
         '{OP_INSERT,  6'd0,  32'd5,        1'b1, '{STS_RANGE, 32'd0, 6'd0, 1'b1}},
         '{OP_INSERT,  6'd2,  32'd5,        1'b1, '{STS_RANGE, 32'd0, 6'd0, 1'b1}},
         '{OP_INSERT,  6'd63, 32'd5,        1'b1, '{STS_RANGE, 32'd0, 6'd0, 1'b1}},
         '{OP_INSERT,  6'd1,  VAL_MAX,      1'b1, '{STS_DONE,  32'd0, 6'd1, 1'b0}},
         '{OP_INSERT,  6'd1,  VAL_MIN,      1'b1, '{STS_DONE,  32'd0, 6'd2, 1'b0}},
         '{OP_INSERT,  6'd3,  VAL_NEG1,     1'b1, '{STS_DONE,  32'd0, 6'd3, 1'b0}},
         '{OP_INSERT,  6'd5,  32'd7,        1'b1, '{STS_RANGE, 32'd0, 6'd3, 1'b0}},
         '{OP_INSERT,  6'd2,  32'h5555AAAA, 1'b0, '0},
         '{OP_EXTRACT, 6'd0,  32'd0,        1'b1, '{STS_RANGE, 32'd0, 6'd4, 1'b0}},
         '{OP_EXTRACT, 6'd5,  32'd0,        1'b1, '{STS_RANGE, 32'd0, 6'd4, 1'b0}},
         '{OP_EXTRACT, 6'd63, 32'd0,        1'b1, '{STS_RANGE, 32'd0, 6'd4, 1'b0}},
         '{OP_EXTRACT, 6'd1,  VAL_NEG1,     1'b0, '0},
         '{OP_EXTRACT, 6'd2,  32'd0,        1'b0, '0},
         '{OP_EXTRACT, 6'd2,  32'd0,        1'b0, '0},
         '{OP_EXTRACT, 6'd1,  32'd0,        1'b0, '0},
         '{OP_EXTRACT, 6'd1,  32'd0,        1'b1, '{STS_RANGE, 32'd0, 6'd0, 1'b1}},
         '{OP_INSERT,  6'd1,  32'hAAAA5555, 1'b0, '0},
         '{OP_EXTRACT, 6'd1,  32'h12345678, 1'b0, '0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i])
         send_word(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
                   dir_rows[i].fixed, dir_rows[i].want);

      // no idling, opening with a long result hold-off so the input backs up
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 1'b1;
      repeat (12) send_checked(OP_INSERT, legal_pos(OP_INSERT), rand_value());
      run_phase(150);

      // sender mostly idle
      send_idle_pct = 82;
      rsp_stall_pct = 0;
      run_phase(155);

      // receiver mostly stalling
      send_idle_pct = 0;
      rsp_stall_pct = 82;
      run_phase(155);

      // both sides idling
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      run_phase(155);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("ran %0d words: %0d inserts, %0d extracts, %0d range and %0d full rejects",
               words_sent, n_insert_done, n_extract_done, n_range_reject, n_full_reject);
      $display("checked %0d result words; list depth peaked at %0d of %0d",
               results_seen, peak_count, LIST_DEPTH);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("run timed out with %0d results outstanding", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
